// ===== design/lbpd_pkg.sv =====
// shared constants and types for the light bar passage direction block
`timescale 1ns / 1ps

package lbpd_pkg;

    // default counter width for the beam counters
    localparam int COUNT_WIDTH = 16;

    // bar patterns with a meaning of their own
    localparam logic [2:0] PAT_CLEAR = 3'b000;
    localparam logic [2:0] PAT_FULL  = 3'b111;

    // verdict codes
    localparam logic [2:0] VERDICT_EXIT       = 3'd0;
    localparam logic [2:0] VERDICT_ENTRY      = 3'd1;
    localparam logic [2:0] VERDICT_EXIT_TB    = 3'd2;
    localparam logic [2:0] VERDICT_ENTRY_TB   = 3'd3;
    localparam logic [2:0] VERDICT_TIE_ERR    = 3'd4;
    localparam logic [2:0] VERDICT_NO_BLOCK   = 3'd5;

    // door codes
    localparam logic DOOR_FRONT = 1'b0;
    localparam logic DOOR_REAR  = 1'b1;

    // result queue depth, must be a power of two and at least 4
    localparam int QUEUE_DEPTH = 4;

    // classification from one bar for one sample
    typedef struct packed {
        logic       fired;
        logic [2:0] verdict;
        logic       direction;
    } bar_res_t;

    // one result word as queued for the output
    typedef struct packed {
        logic       door;
        logic [2:0] verdict;
        logic       direction;
        logic       last;
    } result_t;

endpackage

// ===== design/lbpd_bar.sv =====
// per-bar beam counters, full-block save and passage classification
`timescale 1ns / 1ps

module lbpd_bar #(
    parameter int COUNT_WIDTH = lbpd_pkg::COUNT_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rear_bar,
    input  logic [2:0]          pattern,
    input  logic                advance,
    output lbpd_pkg::bar_res_t  res
);

    logic [2:0]             prev_pat_reg, prev_pat_next;
    logic                   known_reg, known_next;
    logic                   clear_seen_reg, clear_seen_next;
    logic                   full_seen_reg, full_seen_next;
    logic [COUNT_WIDTH-1:0] saved_a_reg, saved_a_next;
    logic [COUNT_WIDTH-1:0] saved_b_reg, saved_b_next;
    logic [COUNT_WIDTH-1:0] run_a_reg, run_a_next;
    logic [COUNT_WIDTH-1:0] run_b_reg, run_b_next;

    logic                   act;
    logic [COUNT_WIDTH-1:0] run_a_mid, run_b_mid;
    logic [COUNT_WIDTH:0]   sum_1, sum_2;
    logic                   exit_dir;
    localparam logic [COUNT_WIDTH-1:0] ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // crosswise sums of saved and running counts
    assign sum_1 = {1'b0, saved_a_reg} + {1'b0, run_b_reg};
    assign sum_2 = {1'b0, saved_b_reg} + {1'b0, run_a_reg};

    // bar acts on a new pattern, clear only on the second clear sample
    assign act = ((pattern != lbpd_pkg::PAT_CLEAR) || clear_seen_reg) &&
                 (!known_reg || (prev_pat_reg != pattern));

    // next state and classification
    always_comb begin
        prev_pat_next  = prev_pat_reg;
        known_next     = known_reg;
        full_seen_next = full_seen_reg;
        saved_a_next   = saved_a_reg;
        saved_b_next   = saved_b_reg;
        run_a_mid      = run_a_reg;
        run_b_mid      = run_b_reg;
        exit_dir       = 1'b0;
        res.fired      = 1'b0;
        res.verdict    = lbpd_pkg::VERDICT_EXIT;
        res.direction  = 1'b0;

        if (act) begin
            prev_pat_next = pattern;
            known_next    = 1'b1;
            if (pattern == lbpd_pkg::PAT_FULL) begin
                if (!full_seen_reg) begin
                    saved_a_next = run_a_reg;
                    saved_b_next = run_b_reg;
                    run_a_mid    = '0;
                    run_b_mid    = '0;
                end
                full_seen_next = 1'b1;
            end else if (pattern == lbpd_pkg::PAT_CLEAR) begin
                res.fired = 1'b1;
                if (full_seen_reg) begin
                    priority if (sum_1 > sum_2) begin
                        res.verdict = lbpd_pkg::VERDICT_EXIT;
                        exit_dir    = 1'b1;
                    end else if (sum_1 < sum_2) begin
                        res.verdict = lbpd_pkg::VERDICT_ENTRY;
                    end else if (saved_a_reg > run_a_reg) begin
                        res.verdict = lbpd_pkg::VERDICT_EXIT_TB;
                        exit_dir    = 1'b1;
                    end else if (saved_a_reg < run_a_reg) begin
                        res.verdict = lbpd_pkg::VERDICT_ENTRY_TB;
                    end else begin
                        res.verdict = lbpd_pkg::VERDICT_TIE_ERR;
                    end
                    // front exit records 0, rear exit records 1
                    if (res.verdict != lbpd_pkg::VERDICT_TIE_ERR) begin
                        res.direction = exit_dir ~^ rear_bar;
                    end
                end else begin
                    res.verdict = lbpd_pkg::VERDICT_NO_BLOCK;
                end
                saved_a_next   = '0;
                saved_b_next   = '0;
                run_a_mid      = '0;
                run_b_mid      = '0;
                full_seen_next = 1'b0;
            end
        end

        // saturating beam counters, full-block samples not counted
        run_a_next = run_a_mid;
        run_b_next = run_b_mid;
        if (pattern != lbpd_pkg::PAT_FULL) begin
            if (pattern[2] && (run_a_mid != '1)) begin
                run_a_next = run_a_mid + ONE;
            end
            if (pattern[1] && (run_b_mid != '1)) begin
                run_b_next = run_b_mid + ONE;
            end
        end
        clear_seen_next = (pattern == lbpd_pkg::PAT_CLEAR);
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pat_reg   <= '0;
            known_reg      <= 1'b0;
            clear_seen_reg <= 1'b0;
            full_seen_reg  <= 1'b0;
            saved_a_reg    <= '0;
            saved_b_reg    <= '0;
            run_a_reg      <= '0;
            run_b_reg      <= '0;
        end else if (advance) begin
            prev_pat_reg   <= prev_pat_next;
            known_reg      <= known_next;
            clear_seen_reg <= clear_seen_next;
            full_seen_reg  <= full_seen_next;
            saved_a_reg    <= saved_a_next;
            saved_b_reg    <= saved_b_next;
            run_a_reg      <= run_a_next;
            run_b_reg      <= run_b_next;
        end
    end

endmodule

// ===== design/lbpd_outq.sv =====
// small result queue taking up to two words per cycle, giving one whenever m_tready is high
`timescale 1ns / 1ps

module lbpd_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_cnt,
    input  lbpd_pkg::result_t  push_a,
    input  lbpd_pkg::result_t  push_b,
    output logic               room,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // door, verdict[2:0], direction, zero pad
    output logic               m_tlast
);

    localparam int DEPTH = lbpd_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    lbpd_pkg::result_t       q_reg [DEPTH];
    logic [PW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [PW:0]             count_reg, count_next;
    logic [PW-1:0]           wr_ptr_b;
    logic                    pop;
    lbpd_pkg::result_t       head;

    assign wr_ptr_b = wr_ptr_reg + {{(PW-1){1'b0}}, 1'b1};
    assign pop      = m_tvalid && m_tready;
    assign room     = count_reg <= (PW+1)'(DEPTH - 2);

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + {{(PW-1){1'b0}}, pop};
        count_next  = count_reg + (PW+1)'(push_cnt) - {{PW{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_ptr_b] <= push_b;
        end
    end

    // output word
    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {3'b000, head.direction, head.verdict, head.door};
    assign m_tlast  = head.last;

endmodule

// ===== design/light_bar_passage_direction.sv =====
// top level: input register, front and rear bar units, result queue
// path: input register, then the bar units, whose results are written into the result queue
// throughput: one word per cycle while the queue has room; two results leave as two words
// rate set by the single-word output port draining a four-entry result queue
// reset: aresetn low clears bar counters, pattern history and the queue
`timescale 1ns / 1ps

module light_bar_passage_direction #(
    parameter int COUNT_WIDTH = lbpd_pkg::COUNT_WIDTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // sensor_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // door, verdict[2:0], direction, zero pad
    output logic       m_tlast
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               proc_fire;
    logic               q_room;
    lbpd_pkg::bar_res_t front_res, rear_res;
    lbpd_pkg::result_t  front_word, rear_word, push_a, push_b;
    logic [1:0]         push_cnt;

    // input register, refilled as its word moves into the bars
    assign proc_fire     = in_valid_reg && q_room;
    assign s_tready      = !in_valid_reg || proc_fire;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !proc_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // bar units
    lbpd_bar #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rear_bar (lbpd_pkg::DOOR_FRONT),
        .pattern  (in_byte_reg[6:4]),
        .advance  (proc_fire),
        .res      (front_res)
    );

    lbpd_bar #(.COUNT_WIDTH(COUNT_WIDTH)) u_rear (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rear_bar (lbpd_pkg::DOOR_REAR),
        .pattern  (in_byte_reg[2:0]),
        .advance  (proc_fire),
        .res      (rear_res)
    );

    // order results front first, last flag on the final one
    always_comb begin
        front_word.door      = lbpd_pkg::DOOR_FRONT;
        front_word.verdict   = front_res.verdict;
        front_word.direction = front_res.direction;
        front_word.last      = !rear_res.fired;
        rear_word.door       = lbpd_pkg::DOOR_REAR;
        rear_word.verdict    = rear_res.verdict;
        rear_word.direction  = rear_res.direction;
        rear_word.last       = 1'b1;
        push_a   = front_res.fired ? front_word : rear_word;
        push_b   = rear_word;
        push_cnt = proc_fire ? ({1'b0, front_res.fired} + {1'b0, rear_res.fired}) : 2'd0;
    end

    // result queue
    lbpd_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b),
        .room     (q_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // nothing comes out right after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result valid right after reset");

    // a pair of results is front then rear, last only on the second
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd2) |->
            (push_a.door == lbpd_pkg::DOOR_FRONT) && (push_b.door == lbpd_pkg::DOOR_REAR) &&
            !push_a.last && push_b.last)
        else $error("bad result pair ordering");

    // a queued word that is not taken reappears unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // only defined verdicts leave the block
    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= lbpd_pkg::VERDICT_NO_BLOCK))
        else $error("undefined verdict code");
`endif

endmodule
